>>> src/zows_pkg.sv
// Shared constants, types and command/status structs for the zone statistics block.
package zows_pkg;

    localparam int MedianTaps  = 5;
    localparam int SampleDepth = 64;
    localparam int TrackDepth  = 64;
    localparam int SampleAw    = $clog2(SampleDepth);
    localparam int TrackAw     = $clog2(TrackDepth);
    localparam int SampleCw    = $clog2(SampleDepth + 1);
    localparam int TrackCw     = $clog2(TrackDepth + 1);
    localparam int FillW       = $clog2(MedianTaps + 1);
    localparam int MedIdxW     = (MedianTaps > 1) ? $clog2(MedianTaps) : 1;
    localparam int DivW        = 30;
    localparam int DivCntW     = $clog2(DivW + 1);

    localparam logic [0:0] CfgWindow   = 1'b0;
    localparam logic [0:0] CfgInterval = 1'b1;

    localparam logic [26:0] WindowReset   = 27'd60000;
    localparam logic [15:0] IntervalReset = 16'd1000;

    typedef enum logic [1:0] {
        DIV_DWELL = 2'd0,
        DIV_ENG   = 2'd1,
        DIV_SPEED = 2'd2
    } div_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic     load;        // capture input item, start item work
        logic     med_step;    // one insertion step of the median sort
        logic     med_done;    // latch median result
        logic     sample_push; // store sample (frame item)
        logic     track_push;  // store track record (removal item)
        logic     evict_track; // drop oldest track (full ring)
        logic     prune_rd;    // issue ring head reads for pruning
        logic     prune_s;     // drop sample head
        logic     prune_t;     // drop track head
        logic     scan_start;
        logic     scan_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_step;
        logic     div_store;
        logic     out_load;
    } zows_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_track;
        logic sample_due;
        logic sample_full;
        logic track_full;
        logic s_old;      // sample head older than window (valid after prune_rd)
        logic t_old;
        logic med_last;
        logic scan_last;
        logic div_last;
        logic out_busy;
    } zows_sts_t;

endpackage

>>> src/zows_datapath.sv
// Datapath: median history, sample and track rings, running sums, peak scan, divider.
module zows_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  zows_pkg::zows_cmd_t cmd,
    output zows_pkg::zows_sts_t sts,
    input  logic                cfg_valid,
    input  logic [0:0]          cfg_index,
    input  logic [26:0]         cfg_data,
    input  logic                s_action,
    input  logic [31:0]         s_time_ms,
    input  logic [7:0]          s_total_count,
    input  logic [7:0]          s_browsing_count,
    input  logic [7:0]          s_engaged_count,
    input  logic [7:0]          s_assist_count,
    input  logic [15:0]         s_entries_seen,
    input  logic [15:0]         s_exits_seen,
    input  logic [23:0]         s_dwell_ms,
    input  logic [23:0]         s_engagement_ms,
    input  logic [15:0]         s_speed_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_occupancy_out,
    output logic [7:0]          m_browsing_out,
    output logic [7:0]          m_engaged_out,
    output logic [7:0]          m_assist_out,
    output logic [15:0]         m_entries_out,
    output logic [15:0]         m_exits_out,
    output logic [7:0]          m_peak_occupancy,
    output logic [23:0]         m_mean_dwell_ms,
    output logic [23:0]         m_mean_engagement_ms,
    output logic [15:0]         m_mean_speed,
    output logic                m_overflow_flag
);
    import zows_pkg::*;

    // configuration
    logic [26:0] window_reg;
    logic [15:0] interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= WindowReset;
            interval_reg <= IntervalReset;
        end else if (cfg_valid) begin
            if (cfg_index == CfgWindow) window_reg <= cfg_data;
            else                        interval_reg <= cfg_data[15:0];
        end
    end

    // captured item
    logic        action_reg;
    logic [31:0] now_reg;
    logic [23:0] dwell_reg, eng_reg;
    logic [15:0] speed_reg;
    logic [23:0] state_reg;
    logic [31:0] flow_reg;
    logic        flag_reg;

    // median
    logic [7:0]         hist_reg [MedianTaps];
    logic [FillW-1:0]   fill_reg;
    logic [7:0]         sorted_reg [MedianTaps];
    logic [MedIdxW-1:0] med_i_reg;
    logic [7:0]         smooth_reg;

    // rings
    logic [39:0]         sring [SampleDepth];
    logic [31:0]         tt_ring [TrackDepth];
    logic [63:0]         tm_ring [TrackDepth];
    logic [SampleAw-1:0] s_head_reg;
    logic [SampleCw-1:0] s_cnt_reg;
    logic [TrackAw-1:0]  t_head_reg;
    logic [TrackCw-1:0]  t_cnt_reg;
    logic [31:0]         last_stamp_reg;
    logic [39:0]         s_rd_reg;
    logic [31:0]         t_time_rd_reg;
    logic [63:0]         t_met_rd_reg;
    logic [29:0]         sum_d_reg, sum_e_reg;
    logic [21:0]         sum_s_reg;

    // scan
    logic [SampleAw-1:0] scan_ptr_reg;
    logic [SampleCw-1:0] scan_left_reg;
    logic                scan_vld_reg;
    logic [7:0]          peak_reg;

    // divider
    logic [DivW-1:0]    quo_reg, rem_reg;
    logic [DivCntW-1:0] div_cnt_reg;
    logic [23:0]        md_reg, me_reg;
    logic [15:0]        ms_reg;

    logic [SampleAw-1:0] s_tail;
    logic [TrackAw-1:0]  t_tail;
    logic [32:0]         s_lim, t_lim;
    logic [DivW:0]       rem_sh;
    logic [DivW:0]       div_diff;

    assign s_tail = SampleAw'(s_head_reg + SampleAw'(s_cnt_reg));
    assign t_tail = TrackAw'(t_head_reg + TrackAw'(t_cnt_reg));
    assign s_lim  = {1'b0, s_rd_reg[39:8]} + 33'(window_reg);
    assign t_lim  = {1'b0, t_time_rd_reg} + 33'(window_reg);
    assign rem_sh = {rem_reg, quo_reg[DivW-1]};
    assign div_diff = rem_sh - (DivW+1)'(t_cnt_reg);

    assign sts.is_track    = action_reg;
    assign sts.sample_due  = (now_reg >= last_stamp_reg)
                           && ((now_reg - last_stamp_reg) >= 32'(interval_reg));
    assign sts.sample_full = (s_cnt_reg == SampleCw'(SampleDepth));
    assign sts.track_full  = (t_cnt_reg == TrackCw'(TrackDepth));
    assign sts.s_old       = (s_cnt_reg != '0) && (s_lim < {1'b0, now_reg});
    assign sts.t_old       = (t_cnt_reg != '0) && (t_lim < {1'b0, now_reg});
    assign sts.med_last    = (32'(med_i_reg) + 1 >= 32'(fill_reg));
    assign sts.scan_last   = (scan_left_reg == '0) && !scan_vld_reg;
    assign sts.div_last    = (div_cnt_reg == DivCntW'(1));
    assign sts.out_busy    = m_valid;

    // ring memories
    always_ff @(posedge aclk) begin
        if (cmd.sample_push) sring[s_tail] <= {now_reg, smooth_reg};
        if (cmd.track_push) begin
            tt_ring[t_tail] <= now_reg;
            tm_ring[t_tail] <= {dwell_reg, eng_reg, speed_reg};
        end
        s_rd_reg      <= cmd.scan_step ? sring[scan_ptr_reg] : sring[s_head_reg];
        t_time_rd_reg <= tt_ring[t_head_reg];
        t_met_rd_reg  <= tm_ring[t_head_reg];
    end

    // item capture, median, ring pointers, sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            smooth_reg     <= '0;
            state_reg      <= '0;
            flow_reg       <= '0;
            last_stamp_reg <= '0;
            s_head_reg     <= '0;
            s_cnt_reg      <= '0;
            t_head_reg     <= '0;
            t_cnt_reg      <= '0;
            sum_d_reg      <= '0;
            sum_e_reg      <= '0;
            sum_s_reg      <= '0;
            flag_reg       <= 1'b0;
            for (int k = 0; k < MedianTaps; k++) hist_reg[k] <= '0;
        end else begin
            if (cmd.load) begin
                action_reg <= s_action;
                now_reg    <= s_time_ms;
                dwell_reg  <= s_dwell_ms;
                eng_reg    <= s_engagement_ms;
                speed_reg  <= s_speed_value;
                flag_reg   <= 1'b0;
                med_i_reg  <= '0;
                if (!s_action) begin
                    state_reg <= {s_browsing_count, s_engaged_count, s_assist_count};
                    flow_reg  <= {s_entries_seen, s_exits_seen};
                    if (fill_reg == FillW'(MedianTaps)) begin
                        for (int k = 0; k < MedianTaps - 1; k++) hist_reg[k] <= hist_reg[k+1];
                        hist_reg[MedianTaps-1] <= s_total_count;
                    end else begin
                        hist_reg[MedIdxW'(fill_reg)] <= s_total_count;
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
            // insertion sort: step i inserts hist[i] into sorted[0..i-1]
            if (cmd.med_step) begin
                for (int k = 0; k < MedianTaps; k++) begin
                    if (32'(k) < 32'(med_i_reg)) begin
                        if (sorted_reg[k] > hist_reg[med_i_reg] && k + 1 < MedianTaps)
                            sorted_reg[k+1] <= sorted_reg[k];
                        if (sorted_reg[k] > hist_reg[med_i_reg]
                            && (k == 0 || !(sorted_reg[k-1] > hist_reg[med_i_reg])))
                            sorted_reg[k] <= hist_reg[med_i_reg];
                    end else if (32'(k) == 32'(med_i_reg)) begin
                        if (k == 0 || !(sorted_reg[k-1] > hist_reg[med_i_reg]))
                            sorted_reg[k] <= hist_reg[med_i_reg];
                    end
                end
                med_i_reg <= MedIdxW'(med_i_reg + 1'b1);
            end
            if (cmd.med_done) smooth_reg <= sorted_reg[MedIdxW'(fill_reg >> 1)];
            if (cmd.sample_push) begin
                if (sts.sample_full) begin
                    s_head_reg <= SampleAw'(s_head_reg + 1'b1);
                    flag_reg   <= 1'b1;
                end else begin
                    s_cnt_reg <= s_cnt_reg + 1'b1;
                end
                last_stamp_reg <= now_reg;
            end
            if (cmd.evict_track) begin
                sum_d_reg  <= sum_d_reg - 30'(t_met_rd_reg[63:40]);
                sum_e_reg  <= sum_e_reg - 30'(t_met_rd_reg[39:16]);
                sum_s_reg  <= sum_s_reg - 22'(t_met_rd_reg[15:0]);
                t_head_reg <= TrackAw'(t_head_reg + 1'b1);
                t_cnt_reg  <= t_cnt_reg - 1'b1;
                flag_reg   <= 1'b1;
            end
            if (cmd.track_push) begin
                sum_d_reg <= sum_d_reg + 30'(dwell_reg);
                sum_e_reg <= sum_e_reg + 30'(eng_reg);
                sum_s_reg <= sum_s_reg + 22'(speed_reg);
                t_cnt_reg <= t_cnt_reg + 1'b1;
            end
            if (cmd.prune_s) begin
                s_head_reg <= SampleAw'(s_head_reg + 1'b1);
                s_cnt_reg  <= s_cnt_reg - 1'b1;
            end
            if (cmd.prune_t) begin
                sum_d_reg  <= sum_d_reg - 30'(t_met_rd_reg[63:40]);
                sum_e_reg  <= sum_e_reg - 30'(t_met_rd_reg[39:16]);
                sum_s_reg  <= sum_s_reg - 22'(t_met_rd_reg[15:0]);
                t_head_reg <= TrackAw'(t_head_reg + 1'b1);
                t_cnt_reg  <= t_cnt_reg - 1'b1;
            end
        end
    end

    // peak scan: one ring read per cycle, compare on the registered data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_vld_reg  <= 1'b0;
            scan_left_reg <= '0;
        end else if (cmd.scan_start) begin
            scan_ptr_reg  <= s_head_reg;
            scan_left_reg <= s_cnt_reg;
            scan_vld_reg  <= 1'b0;
            peak_reg      <= '0;
        end else if (cmd.scan_step) begin
            scan_vld_reg <= (scan_left_reg != '0);
            if (scan_left_reg != '0) begin
                scan_ptr_reg  <= SampleAw'(scan_ptr_reg + 1'b1);
                scan_left_reg <= scan_left_reg - 1'b1;
            end
            if (scan_vld_reg && s_rd_reg[7:0] > peak_reg) peak_reg <= s_rd_reg[7:0];
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            unique case (cmd.div_sel)
                DIV_DWELL: quo_reg <= sum_d_reg;
                DIV_ENG:   quo_reg <= sum_e_reg;
                DIV_SPEED: quo_reg <= DivW'(sum_s_reg);
                default:   quo_reg <= '0;
            endcase
            rem_reg     <= '0;
            div_cnt_reg <= DivCntW'(DivW);
        end else if (cmd.div_step) begin
            if (!div_diff[DivW]) begin
                rem_reg <= div_diff[DivW-1:0];
                quo_reg <= {quo_reg[DivW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DivW-1:0];
                quo_reg <= {quo_reg[DivW-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.div_store) begin
            unique case (cmd.div_sel)
                DIV_DWELL: md_reg <= (t_cnt_reg == '0) ? '0 : quo_reg[23:0];
                DIV_ENG:   me_reg <= (t_cnt_reg == '0) ? '0 : quo_reg[23:0];
                DIV_SPEED: ms_reg <= (t_cnt_reg == '0) ? '0 : quo_reg[15:0];
                default:   ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.out_load) begin
                m_valid              <= 1'b1;
                m_occupancy_out      <= smooth_reg;
                m_browsing_out       <= state_reg[23:16];
                m_engaged_out        <= state_reg[15:8];
                m_assist_out         <= state_reg[7:0];
                m_entries_out        <= flow_reg[31:16];
                m_exits_out          <= flow_reg[15:0];
                m_peak_occupancy     <= peak_reg;
                m_mean_dwell_ms      <= md_reg;
                m_mean_engagement_ms <= me_reg;
                m_mean_speed         <= ms_reg;
                m_overflow_flag      <= flag_reg;
            end
        end
    end

endmodule

>>> src/zows_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module zows_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output zows_pkg::zows_cmd_t cmd,
    input  zows_pkg::zows_sts_t sts
);
    import zows_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MED, ST_MED_DONE, ST_PUSH, ST_EVICT_RD, ST_EVICT, ST_TPUSH,
        ST_PRD, ST_PWAIT, ST_PCHK, ST_SCAN, ST_DLOAD, ST_DIV, ST_DSTORE, ST_OUT
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:     cmd.load = s_valid;
            ST_MED:      cmd.med_step = 1'b1;
            ST_MED_DONE: cmd.med_done = 1'b1;
            ST_PUSH:     cmd.sample_push = sts.sample_due;
            ST_EVICT_RD: cmd.prune_rd = 1'b1;
            ST_EVICT:    cmd.evict_track = sts.track_full;
            ST_TPUSH:    cmd.track_push = 1'b1;
            ST_PRD:      cmd.prune_rd = 1'b1;
            ST_PWAIT:    cmd.prune_rd = 1'b1;
            ST_PCHK: begin
                // removal items never prune
                cmd.prune_s    = !sts.is_track && sts.s_old;
                cmd.prune_t    = !sts.is_track && !sts.s_old && sts.t_old;
                cmd.scan_start = sts.is_track || (!sts.s_old && !sts.t_old);
            end
            ST_SCAN:     cmd.scan_step = 1'b1;
            ST_DLOAD:    cmd.div_start = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_DSTORE:   cmd.div_store = 1'b1;
            ST_OUT:      cmd.out_load = !sts.out_busy;
            default:     ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_DWELL;
        end else begin
            unique case (state_reg)
                ST_IDLE:     if (s_valid) state_reg <= ST_MED;
                ST_MED: begin
                    if (sts.is_track) state_reg <= ST_EVICT_RD;
                    else if (sts.med_last) state_reg <= ST_MED_DONE;
                end
                ST_MED_DONE: state_reg <= ST_PUSH;
                ST_PUSH:     state_reg <= ST_PRD;
                ST_EVICT_RD: state_reg <= ST_EVICT;
                ST_EVICT:    state_reg <= ST_TPUSH;
                ST_TPUSH: begin
                    state_reg <= ST_PCHK;
                end
                ST_PRD:      state_reg <= ST_PWAIT;
                ST_PWAIT:    state_reg <= ST_PCHK;
                ST_PCHK: begin
                    if (sts.is_track) state_reg <= ST_SCAN;
                    else if (sts.s_old || sts.t_old) state_reg <= ST_PRD;
                    else state_reg <= ST_SCAN;
                end
                ST_SCAN: if (sts.scan_last) begin
                    state_reg <= ST_DLOAD;
                    sel_reg   <= DIV_DWELL;
                end
                ST_DLOAD:    state_reg <= ST_DIV;
                ST_DIV:      if (sts.div_last) state_reg <= ST_DSTORE;
                ST_DSTORE: begin
                    if (sel_reg == DIV_SPEED) begin
                        state_reg <= ST_OUT;
                    end else begin
                        sel_reg   <= (sel_reg == DIV_DWELL) ? DIV_ENG : DIV_SPEED;
                        state_reg <= ST_DLOAD;
                    end
                end
                ST_OUT:      if (!sts.out_busy) state_reg <= ST_IDLE;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> src/zone_occupancy_window_stats.sv
// Top level of the zone occupancy smoothing and sliding-window statistics block.
// A frame item runs the median sort (one step per history entry, fill up to 5), the
// sample push and the prune loop; a removal item evicts the oldest track if the ring
// is full and pushes its record. Both then scan the stored samples for the peak and
// run three serial 30-bit divisions (load, 30 steps, store); one item is taken at a time.
// Reset: aresetn synchronous active low; clears history, pointers, sums; config to defaults.
module zone_occupancy_window_stats (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [26:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_time_ms,
    input  logic [7:0]  s_total_count,
    input  logic [7:0]  s_browsing_count,
    input  logic [7:0]  s_engaged_count,
    input  logic [7:0]  s_assist_count,
    input  logic [15:0] s_entries_seen,
    input  logic [15:0] s_exits_seen,
    input  logic [23:0] s_dwell_ms,
    input  logic [23:0] s_engagement_ms,
    input  logic [15:0] s_speed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_occupancy_out,
    output logic [7:0]  m_browsing_out,
    output logic [7:0]  m_engaged_out,
    output logic [7:0]  m_assist_out,
    output logic [15:0] m_entries_out,
    output logic [15:0] m_exits_out,
    output logic [7:0]  m_peak_occupancy,
    output logic [23:0] m_mean_dwell_ms,
    output logic [23:0] m_mean_engagement_ms,
    output logic [15:0] m_mean_speed,
    output logic        m_overflow_flag
);
    import zows_pkg::*;

    zows_cmd_t cmd;
    zows_sts_t sts;

    // config writes are always taken; the user must write config only while the block is idle (not enforced here)
    assign cfg_ready = 1'b1;

    zows_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    zows_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_action             (s_action),
        .s_time_ms            (s_time_ms),
        .s_total_count        (s_total_count),
        .s_browsing_count     (s_browsing_count),
        .s_engaged_count      (s_engaged_count),
        .s_assist_count       (s_assist_count),
        .s_entries_seen       (s_entries_seen),
        .s_exits_seen         (s_exits_seen),
        .s_dwell_ms           (s_dwell_ms),
        .s_engagement_ms      (s_engagement_ms),
        .s_speed_value        (s_speed_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_occupancy_out      (m_occupancy_out),
        .m_browsing_out       (m_browsing_out),
        .m_engaged_out        (m_engaged_out),
        .m_assist_out         (m_assist_out),
        .m_entries_out        (m_entries_out),
        .m_exits_out          (m_exits_out),
        .m_peak_occupancy     (m_peak_occupancy),
        .m_mean_dwell_ms      (m_mean_dwell_ms),
        .m_mean_engagement_ms (m_mean_engagement_ms),
        .m_mean_speed         (m_mean_speed),
        .m_overflow_flag      (m_overflow_flag)
    );

`ifndef SYNTHESIS
    // a transfer is taken only while idle, never while a result is being loaded
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.out_load) else $error("load and out_load together");
    // pruning only ever drops one ring head per cycle
    a_single_prune: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.prune_s && cmd.prune_t)) else $error("double prune");
    // a result is loaded only into an empty output register
    a_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid) else $error("output overwritten");
`endif

endmodule
